[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[hdl/rsmp_pkg.sv]
// ----------------------------------------------------------------------------
// rsmp_pkg
// Types, register codes and helpers of the ADC to audio resampler.
// ----------------------------------------------------------------------------
package rsmp_pkg;

  typedef struct packed {
    logic               sample_valid;
    logic signed [23:0] adc_sample;
  } in_t;

  typedef struct packed {
    logic signed [23:0] out_sample;
    logic               sample_taken;
  } out_t;

  typedef struct packed {
    logic [31:0]       phase_step;
    logic              wide_output;
    logic signed [3:0] gain_shift;
    logic [3:0]        smooth_shift;
    logic              median_enable;
    logic [14:0]       target_peak;
  } cfg_t;

  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PHASE_STEP    = 3'd0,
    REG_WIDE_OUTPUT   = 3'd1,
    REG_GAIN_SHIFT    = 3'd2,
    REG_SMOOTH_SHIFT  = 3'd3,
    REG_MEDIAN_ENABLE = 3'd4,
    REG_TARGET_PEAK   = 3'd5
  } reg_idx_t;

  typedef enum logic {
    MUL_INTERP = 1'b0,
    MUL_PEAK   = 1'b1
  } mul_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic     take;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     gain_en;
    logic     smooth_en;
    logic     fin;
  } cmd_t;

  localparam logic [14:0] TARGET_PEAK_RST  = 15'd30000;
  localparam logic [3:0]  SMOOTH_SHIFT_RST = 4'd2;

  localparam logic signed [31:0] MAX24 = 32'sh007F_FFFF;
  localparam logic signed [31:0] MIN24 = 32'shFF80_0000;
  localparam logic signed [23:0] MAX16 = 24'sh00_7FFF;
  localparam logic signed [23:0] MIN16 = 24'shFF_8000;

  function automatic logic signed [23:0] mid3(input logic signed [23:0] a,
                                              input logic signed [23:0] b,
                                              input logic signed [23:0] c);
    logic signed [23:0] lo;
    logic signed [23:0] hi;
    logic signed [23:0] m;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    m  = (hi < c) ? hi : c;
    return (lo > m) ? lo : m;
  endfunction

endpackage

[hdl/rsmp_ctrl.sv]
// ----------------------------------------------------------------------------
// rsmp_ctrl
// Sequencer: walks one request through the datapath steps, owns out_valid.
// ----------------------------------------------------------------------------
module rsmp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output rsmp_pkg::cmd_t cmd
);
  import rsmp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_GAIN,
    S_SMOOTH,
    S_MUL2,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.mul_sel   = MUL_INTERP;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_GAIN;
      end
      S_GAIN: begin
        cmd.gain_en = 1'b1;
        state_nxt   = S_SMOOTH;
      end
      S_SMOOTH: begin
        cmd.smooth_en = 1'b1;
        state_nxt     = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_PEAK;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        // hold until the output register can take the result
        if (slot_free) begin
          cmd.fin       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hdl/rsmp_dp.sv]
// ----------------------------------------------------------------------------
// rsmp_dp
// Datapath: sample intake with median window, shared multiplier, gain,
// smoother, output mapping and phase accumulator.
// ----------------------------------------------------------------------------
module rsmp_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  rsmp_pkg::cfg_t cfg,
  input  rsmp_pkg::cmd_t cmd,
  input  rsmp_pkg::in_t  in_data,
  output rsmp_pkg::out_t out_data
);
  import rsmp_pkg::*;

  logic [31:0]        phase_acc_r;
  logic signed [23:0] cur_r;
  logic signed [23:0] next_r;
  logic               held_r;
  logic signed [31:0] smooth_r;
  logic signed [23:0] win_r [3];
  logic               taken_r;
  logic [14:0]        frac_r;
  logic signed [48:0] prod_r;
  logic signed [30:0] gained_r;
  out_t               out_data_r;

  logic               take_now;
  logic signed [23:0] med;
  logic signed [24:0] diff;
  logic signed [32:0] op_a;
  logic signed [15:0] op_b;
  logic signed [48:0] prod;
  logic signed [24:0] interp_w;
  logic signed [30:0] vext;
  logic signed [30:0] gained_nxt;
  logic [3:0]         rsh;
  logic signed [32:0] sdiff;
  logic signed [32:0] sdiff_sh;
  logic signed [32:0] ysum;
  logic signed [23:0] scaled;
  logic signed [23:0] narrow;
  logic signed [23:0] result;
  logic [32:0]        phase_sum;

  assign take_now = in_data.sample_valid && !held_r;
  assign med      = mid3(win_r[1], win_r[2], in_data.adc_sample);

  // shared multiplier: interpolation weight, then target peak scaling
  assign diff = 25'(next_r) - 25'(cur_r);
  assign op_a = (cmd.mul_sel == MUL_INTERP) ? 33'(diff) : 33'(smooth_r);
  assign op_b = (cmd.mul_sel == MUL_INTERP) ? $signed({1'b0, frac_r})
                                            : $signed({1'b0, cfg.target_peak});
  assign prod = op_a * op_b;

  // blend stays between current and next, so 24 bits suffice
  assign interp_w = 25'(cur_r) + prod_r[39:15];
  assign vext     = 31'(interp_w);
  assign rsh      = 4'(-cfg.gain_shift);

  always_comb begin
    if (cfg.gain_shift[3]) begin
      gained_nxt = vext >>> rsh;
    end else begin
      gained_nxt = vext <<< cfg.gain_shift[2:0];
    end
  end

  assign sdiff    = 33'(gained_r) - 33'(smooth_r);
  assign sdiff_sh = sdiff >>> cfg.smooth_shift;
  assign ysum     = 33'(smooth_r) + sdiff_sh;

  assign scaled = prod_r[46:23];

  always_comb begin
    if (scaled > MAX16) begin
      narrow = MAX16;
    end else if (scaled < MIN16) begin
      narrow = MIN16;
    end else begin
      narrow = scaled;
    end
    if (!cfg.wide_output) begin
      result = narrow;
    end else if (smooth_r > MAX24) begin
      result = MAX24[23:0];
    end else if (smooth_r < MIN24) begin
      result = MIN24[23:0];
    end else begin
      result = smooth_r[23:0];
    end
  end

  assign phase_sum = {1'b0, phase_acc_r} + {1'b0, cfg.phase_step};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r <= '0;
      cur_r       <= '0;
      next_r      <= '0;
      held_r      <= 1'b0;
      smooth_r    <= '0;
      win_r[0]    <= '0;
      win_r[1]    <= '0;
      win_r[2]    <= '0;
    end else begin
      if (cmd.take && take_now) begin
        if (cfg.median_enable) begin
          win_r[0] <= win_r[1];
          win_r[1] <= win_r[2];
          win_r[2] <= in_data.adc_sample;
          next_r   <= med;
        end else begin
          next_r <= in_data.adc_sample;
        end
        held_r <= 1'b1;
      end
      if (cmd.smooth_en) begin
        smooth_r <= ysum[31:0];
      end
      if (cmd.fin) begin
        phase_acc_r <= phase_sum[31:0];
        // wrap: look-ahead becomes current and is released
        if (phase_sum[32]) begin
          cur_r  <= next_r;
          held_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      taken_r <= take_now;
      frac_r  <= phase_acc_r[31:17];
    end
    if (cmd.mul_en) begin
      prod_r <= prod;
    end
    if (cmd.gain_en) begin
      gained_r <= gained_nxt;
    end
    if (cmd.fin) begin
      out_data_r.out_sample   <= result;
      out_data_r.sample_taken <= taken_r;
    end
  end

  assign out_data = out_data_r;

endmodule

[hdl/adc_to_audio_resampler_top.sv]
// ----------------------------------------------------------------------------
// adc_to_audio_resampler_top
// Linear-interpolation resampler from a 24-bit ADC stream to audio frames.
// ----------------------------------------------------------------------------
// One request per output frame tick. A request is accepted while idle and
// walks the steps in order: first multiply, gain, smoother, second multiply
// and finish, where its result is written to the output register; only then
// can the next request be accepted. One shared 33x16 multiplier is used
// twice in sequence (interpolation weight, then target peak scaling). A
// finished result waits in the output register while the next request is
// already accepted; if that register is still held at the end of the next
// request, the request waits in its last step. Configuration writes are
// always ready and must be issued while idle.
module adc_to_audio_resampler_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  rsmp_pkg::in_t               in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output rsmp_pkg::out_t              out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rsmp_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0]                 cfg_data
);
  import rsmp_pkg::*;

  cfg_t cfg_r;
  cmd_t cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_step    <= '0;
      cfg_r.wide_output   <= 1'b1;
      cfg_r.gain_shift    <= '0;
      cfg_r.smooth_shift  <= SMOOTH_SHIFT_RST;
      cfg_r.median_enable <= 1'b1;
      cfg_r.target_peak   <= TARGET_PEAK_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PHASE_STEP:    cfg_r.phase_step    <= cfg_data;
        REG_WIDE_OUTPUT:   cfg_r.wide_output   <= cfg_data[0];
        REG_GAIN_SHIFT:    cfg_r.gain_shift    <= $signed(cfg_data[3:0]);
        REG_SMOOTH_SHIFT:  cfg_r.smooth_shift  <= cfg_data[3:0];
        REG_MEDIAN_ENABLE: cfg_r.median_enable <= cfg_data[0];
        REG_TARGET_PEAK:   cfg_r.target_peak   <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  rsmp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  rsmp_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

[hdl/rsmp_chk.sv]
// ----------------------------------------------------------------------------
// rsmp_chk
// Port-level checks of the resampler, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsmp_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input rsmp_pkg::out_t               out_data
);

  // a request keeps the block busy for the following cycle
  `ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_valid && !in_stall, in_stall)

  // results only come out of a request in progress
  `ASSERT_SAME(a_result_from_work, clk, rst_n, $rose(out_valid), $past(in_stall))

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_data))

endmodule

bind adc_to_audio_resampler_top rsmp_chk u_chk (.*);
